FILE: src/gbs_pkg.sv
package gbs_pkg;

    localparam int GROUPS = 1024;
    localparam int IDX_W  = (GROUPS > 2) ? $clog2(GROUPS) : 1;
    localparam int CNT_W  = $clog2(GROUPS + 1);
    localparam int QDEPTH = 4;
    localparam int QA_W   = $clog2(QDEPTH);
    localparam int QC_W   = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic signed [31:0] group_key;
        logic signed [31:0] agg_value;
    } t_item;

    typedef struct packed {
        logic signed [31:0] out_key;
        logic signed [31:0] group_sum;
        logic               new_group;
        logic               table_full;
    } t_result;

    // word handed from front to back: row plus its home slot
    typedef struct packed {
        logic [31:0]      key;
        logic [31:0]      val;
        logic [IDX_W-1:0] home;
    } t_row;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] sum;
        logic        valid;
    } t_slot;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK
    } t_state;

    // xor fold of the key onto the slot index, folded back below GROUPS
    function automatic logic [IDX_W-1:0] hash_key(input logic [31:0] k);
        logic [IDX_W-1:0] h;
        logic [IDX_W:0]   w;
        h = '0;
        for (int i = 0; i < 32; i++) begin
            h[i % IDX_W] = h[i % IDX_W] ^ k[i];
        end
        w = {1'b0, h};
        if (w >= (IDX_W+1)'(GROUPS)) begin
            w = w - (IDX_W+1)'(GROUPS);
        end
        return w[IDX_W-1:0];
    endfunction

endpackage

FILE: src/gbs_front.sv
module gbs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gbs_pkg::t_item i_item,
    output logic          o_full,
    output logic          o_row_valid,
    output gbs_pkg::t_row o_row,
    input  logic          i_pop
);
    import gbs_pkg::*;

    t_row             r_q [QDEPTH];
    logic [QA_W-1:0]  r_wr;
    logic [QA_W-1:0]  r_rd;
    logic [QC_W-1:0]  r_cnt;
    logic             push_ok;
    logic             pop_ok;
    t_row             row_in;

    assign o_full      = (r_cnt == QC_W'(QDEPTH));
    assign o_row_valid = (r_cnt != '0);
    assign push_ok     = i_push && !o_full;
    assign pop_ok      = i_pop && o_row_valid;
    assign o_row       = r_q[r_rd];

    always_comb begin
        row_in.key  = i_item.group_key;
        row_in.val  = i_item.agg_value;
        row_in.home = hash_key(i_item.group_key);
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wr] <= row_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= (r_wr == QA_W'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= (r_rd == QA_W'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({push_ok, pop_ok})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QC_W'(QDEPTH))
        else $error("queue count out of range");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0 && !push_ok) |=> (r_cnt == '0))
        else $error("queue count moved without a push");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wr == r_rd))
        else $error("empty queue with pointers apart");

endmodule

FILE: src/gbs_back.sv
module gbs_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_row_valid,
    input  gbs_pkg::t_row     i_row,
    output logic              o_pop,
    output logic              o_clearing,
    output logic              o_done,
    output gbs_pkg::t_result  o_result
);
    import gbs_pkg::*;

    t_slot            mem [GROUPS];
    t_slot            r_rd_data;

    t_state           r_state, n_state;
    logic [31:0]      r_key, n_key;
    logic [31:0]      r_val, n_val;
    logic [IDX_W-1:0] r_addr, n_addr;
    logic [CNT_W-1:0] r_probe, n_probe;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_clr, n_clr;
    logic             r_done, n_done;
    t_result          r_res, n_res;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_slot            wr_data;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] addr_nx;

    assign addr_nx    = (r_addr == IDX_W'(GROUPS - 1)) ? '0 : r_addr + 1'b1;
    assign o_clearing = (r_state == S_CLEAR);
    assign o_done     = r_done;
    assign o_result   = r_res;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_val <= n_val;
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
            r_probe <= '0;
            r_count <= '0;
            r_clr   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_probe <= n_probe;
            r_count <= n_count;
            r_clr   <= n_clr;
            r_done  <= n_done;
        end
    end

    always_comb begin
        n_state = r_state;
        n_key   = r_key;
        n_val   = r_val;
        n_addr  = r_addr;
        n_probe = r_probe;
        n_count = r_count;
        n_clr   = r_clr;
        n_done  = 1'b0;
        n_res   = r_res;
        o_pop   = 1'b0;
        wr_en   = 1'b0;
        wr_addr = r_addr;
        wr_data = '0;
        rd_addr = addr_nx;

        case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                n_clr   = r_clr + 1'b1;
                if (r_clr == IDX_W'(GROUPS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                rd_addr = i_row.home;
                if (i_row_valid) begin
                    o_pop   = 1'b1;
                    n_key   = i_row.key;
                    n_val   = i_row.val;
                    n_addr  = i_row.home;
                    n_probe = '0;
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_res.out_key = r_key;
                if (!r_rd_data.valid && r_count != CNT_W'(GROUPS)) begin
                    // empty slot ends the chain: insert here
                    wr_en            = 1'b1;
                    wr_data.valid    = 1'b1;
                    wr_data.key      = r_key;
                    wr_data.sum      = r_val;
                    n_count          = r_count + 1'b1;
                    n_res.group_sum  = r_val;
                    n_res.new_group  = 1'b1;
                    n_res.table_full = 1'b0;
                    n_done           = 1'b1;
                    n_state          = S_IDLE;
                end else if (r_rd_data.valid && r_rd_data.key == r_key) begin
                    wr_en            = 1'b1;
                    wr_data.valid    = 1'b1;
                    wr_data.key      = r_key;
                    wr_data.sum      = r_rd_data.sum + r_val;
                    n_res.group_sum  = r_rd_data.sum + r_val;
                    n_res.new_group  = 1'b0;
                    n_res.table_full = 1'b0;
                    n_done           = 1'b1;
                    n_state          = S_IDLE;
                end else if (r_probe == CNT_W'(GROUPS - 1)) begin
                    // every slot probed, key absent
                    n_res.group_sum  = '0;
                    n_res.new_group  = 1'b0;
                    n_res.table_full = 1'b1;
                    n_done           = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    n_addr  = addr_nx;
                    n_probe = r_probe + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(GROUPS))
        else $error("entry count above table size");
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_result.new_group && o_result.table_full))
        else $error("new group and table full together");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.new_group) |-> (r_count == $past(r_count) + 1'b1))
        else $error("insert without count step");
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.table_full) |-> (r_count == CNT_W'(GROUPS)))
        else $error("drop while entries free");
    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_clearing |-> !o_pop)
        else $error("row taken during clear pass");

endmodule

FILE: src/group_by_sum_table.sv
// channel   dir  handshake            word
// input     in   start & !busy        i_item   (group_key, agg_value)
// result    out  o_done, one cycle    o_result (out_key, group_sum, new_group, table_full)
//
// A row is looked up at its home slot, then by linear probing through the following
// slots (wrapping to slot 0); a dropped row probes all GROUPS slots. The result is
// registered in the cycle after the lookup ends; a 4-word queue sits in front.
// After reset busy stays high while the slot valid marks of all GROUPS slots are cleared.
// busy rises when the queue is full; results cannot be held off by the receiver.
module group_by_sum_table (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  gbs_pkg::t_item   i_item,
    output logic             o_done,
    output gbs_pkg::t_result o_result
);
    import gbs_pkg::*;

    logic q_full;
    logic row_valid;
    logic pop;
    logic clearing;
    t_row row;

    assign busy = q_full || clearing;

    gbs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (start && !clearing),
        .i_item      (i_item),
        .o_full      (q_full),
        .o_row_valid (row_valid),
        .o_row       (row),
        .i_pop       (pop)
    );

    gbs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_row_valid (row_valid),
        .i_row       (row),
        .o_pop       (pop),
        .o_clearing  (clearing),
        .o_done      (o_done),
        .o_result    (o_result)
    );

endmodule

FILE: dv/tb_group_by_sum_table.sv
module tb_group_by_sum_table;

    import gbs_pkg::*;

    localparam int CYCLE_LIMIT = 6_000_000;
    localparam int POOL_SIZE   = 48;
    localparam int RANDOM_ROWS = 150;
    localparam int FULL_ROWS   = 24;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    logic    busy;
    t_item   i_item  = '0;
    logic    o_done;
    t_result o_result;

    // running sum per distinct key, as the table should hold it
    bit [31:0] sum_by_key [bit [31:0]];
    t_result   due_results [$];
    t_result   oldest;
    bit [31:0] key_pool [POOL_SIZE];
    bit        no_gaps     = 1'b0;
    int        error_count = 0;
    longint    cycle_count = 0;

    group_by_sum_table uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_item mk_row(input logic [31:0] k, input logic [31:0] v);
        t_item r;
        r.group_key = k;
        r.agg_value = v;
        return r;
    endfunction

    // lookup / insert / drop, same as the table does it
    function automatic t_result fold_row(input t_item row);
        t_result   r;
        bit [31:0] k;
        bit [31:0] v;
        k            = row.group_key;
        v            = row.agg_value;
        r.out_key    = row.group_key;
        r.new_group  = 1'b0;
        r.table_full = 1'b0;
        if (sum_by_key.exists(k)) begin
            sum_by_key[k] = sum_by_key[k] + v;
            r.group_sum   = sum_by_key[k];
        end else if (sum_by_key.num() < GROUPS) begin
            sum_by_key[k] = v;
            r.group_sum   = v;
            r.new_group   = 1'b1;
        end else begin
            r.group_sum   = '0;
            r.table_full  = 1'b1;
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 19))
            0: return 32'h0000_0000;
            1: return 32'h0000_0001;
            2: return 32'hFFFF_FFFF;
            3: return 32'h7FFF_FFFF;
            4: return 32'h8000_0000;
            default: return $urandom();
        endcase
    endfunction

    // busy read right after the edge is still its pre-edge value
    task automatic send_row(input t_item row);
        int gap;
        gap = pick_gap();
        start  <= 1'b1;
        i_item <= row;
        do @(posedge i_clk); while (busy);
        due_results.insert(due_results.size(), fold_row(row));
        if (gap > 0) begin
            start  <= 1'b0;
            i_item <= mk_row($urandom(), $urandom());
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("group_by_sum_table verification failed");
            $finish;
        end
        if (i_rst_n && o_done) begin
            if (due_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result word: expected none, got %h",
                         $time, o_result);
            end else begin
                oldest = due_results.pop_front();
                check_field("out_key",    oldest.out_key,    o_result.out_key);
                check_field("group_sum",  oldest.group_sum,  o_result.group_sum);
                check_field("new_group",  32'(oldest.new_group),
                            32'(o_result.new_group));
                check_field("table_full", 32'(oldest.table_full),
                            32'(o_result.table_full));
            end
        end
    end

    task automatic test_directed();
        t_item rows [$];
        rows.insert(rows.size(), mk_row(32'h0000_0000, 32'h0000_0000));
        rows.insert(rows.size(), mk_row(32'h0000_0000, 32'hFFFF_FFFF));
        rows.insert(rows.size(), mk_row(32'h7FFF_FFFF, 32'h7FFF_FFFF));
        rows.insert(rows.size(), mk_row(32'h7FFF_FFFF, 32'h0000_0001));  // positive overflow
        rows.insert(rows.size(), mk_row(32'h8000_0000, 32'h8000_0000));
        rows.insert(rows.size(), mk_row(32'h8000_0000, 32'h8000_0000));  // wraps to zero
        rows.insert(rows.size(), mk_row(32'hFFFF_FFFF, 32'hFFFF_FFFF));
        rows.insert(rows.size(), mk_row(32'hFFFF_FFFF, 32'h0000_0001));
        // keys folding onto slots 0 and 1 build a probe chain
        rows.insert(rows.size(), mk_row(32'h0000_0001, 32'h7FFF_FFFF));
        rows.insert(rows.size(), mk_row(32'h0000_0400, 32'h0000_0001));
        rows.insert(rows.size(), mk_row(32'h0010_0000, 32'h0000_0005));
        rows.insert(rows.size(), mk_row(32'h0000_0401, 32'h8000_0000));
        rows.insert(rows.size(), mk_row(32'h0000_0400, 32'hFFFF_FFFF));
        rows.insert(rows.size(), mk_row(32'h0010_0000, 32'h7FFF_FFFF));
        rows.insert(rows.size(), mk_row(32'h0000_0401, 32'h0000_0001));
        rows.insert(rows.size(), mk_row(32'hAAAA_AAAA, 32'h5555_5555));
        rows.insert(rows.size(), mk_row(32'h5555_5555, 32'hAAAA_AAAA));
        rows.insert(rows.size(), mk_row(32'hAAAA_AAAA, 32'hAAAA_AAAA));
        // top slot, then a second key there so the probe wraps to slot 0
        rows.insert(rows.size(), mk_row(32'h0000_03FF, 32'h1234_5678));
        rows.insert(rows.size(), mk_row(32'h000F_FC00, 32'h0000_0001));
        rows.insert(rows.size(), mk_row(32'h000F_FC00, 32'hFFFF_FFFF));
        rows.insert(rows.size(), mk_row(32'h0000_03FF, 32'h0000_0001));
        foreach (rows[i]) begin
            send_row(rows[i]);
        end
    endtask

    task automatic test_random_groups();
        logic [31:0] k;
        int          r;
        foreach (key_pool[i]) begin
            key_pool[i] = ($urandom_range(0, 5) == 0) ? $urandom() : $urandom_range(0, 300);
        end
        for (int n = 0; n < RANDOM_ROWS; n++) begin
            if (n % 50 == 0) begin
                no_gaps = ($urandom_range(0, 2) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < 70) begin
                k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            end else if (r < 88) begin
                k = $urandom();
            end else begin
                // high bits that fold back onto the low bits of the slot index
                k = $urandom_range(0, 1023) ^ ($urandom_range(1, 1023) << 10);
            end
            send_row(mk_row(k, pick_value()));
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_fill_to_full();
        logic [31:0] candidate;
        candidate = '0;
        while (sum_by_key.num() < GROUPS) begin
            if (!sum_by_key.exists(candidate)) begin
                send_row(mk_row(candidate, $urandom()));
            end
            candidate++;
        end
    endtask

    // held keys still add; unknown keys come back dropped
    task automatic test_after_full();
        logic [31:0] k;
        for (int n = 0; n < FULL_ROWS; n++) begin
            if (n % 2 == 0) begin
                k = $urandom_range(0, 500);
            end else begin
                do k = $urandom(); while (sum_by_key.exists(k));
            end
            send_row(mk_row(k, pick_value()));
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_groups();
        test_fill_to_full();
        test_after_full();
        start <= 1'b0;
        while (due_results.size() > 0) @(posedge i_clk);
        repeat (4 * GROUPS + 16) @(posedge i_clk);
        if (error_count == 0) begin
            $display("group_by_sum_table verification clean");
        end else begin
            $display("group_by_sum_table verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/gbs_pkg.sv
src/gbs_front.sv
src/gbs_back.sv
src/group_by_sum_table.sv
dv/tb_group_by_sum_table.sv
